FILE: design/mcas_pkg.sv
// Shared constants, cell command type and codes for the min-cost assignment solver.
// No dependencies; the interfaces, mcas_cell and the top level import this package.
package mcas_pkg;

	localparam int MAX_PORTS_DEF = 16;
	localparam int RESULT_CAP    = 16;
	localparam int RC_W          = 4;
	localparam int COST_W        = 40;
	localparam int VAL_W         = 52;
	localparam int CFG_W         = 5;

	localparam logic [CFG_W-1:0]        CFG_RESET  = 5'd16;
	localparam logic [COST_W-1:0]       COST_RESET = 40'd1000000000000;
	localparam logic signed [VAL_W-1:0] SLACK_INF  = 52'sd1000000000000000;

	// item action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SOLVE = 1'b1;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_SOLVE_INIT,
		CMD_ROW_INIT,
		CMD_MARK,
		CMD_SHIFT,
		CMD_SUB_V,
		CMD_SLACK,
		CMD_APPLY,
		CMD_SET_MATCH
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [VAL_W-1:0]   arg;
	} cell_cmd_t;

endpackage

FILE: design/mcas_ifs.sv
// Handshake channels of the assignment solver: item input, result output, config write.
// Depends on mcas_pkg for field widths.
interface mcas_in_if;
	import mcas_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [RC_W-1:0]   row;
	logic [RC_W-1:0]   col;
	logic [COST_W-1:0] cost;
	modport source (output valid, action, row, col, cost, input ready);
	modport sink (input valid, action, row, col, cost, output ready);
endinterface

interface mcas_out_if;
	import mcas_pkg::*;
	logic            valid;
	logic            ready;
	logic [RC_W-1:0] source_row;
	logic [RC_W-1:0] assigned_target;
	logic            last;
	modport source (output valid, source_row, assigned_target, last, input ready);
	modport sink (input valid, source_row, assigned_target, last, output ready);
endinterface

interface mcas_cfg_if;
	import mcas_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: design/mcas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcas_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/mcas_cell.sv
// One column cell of the solver chain: column potential, slack, used flag, match, back link.
// Depends on mcas_pkg; instantiated once per column by the top level.
module mcas_cell #(
	parameter int MAX_PORTS = mcas_pkg::MAX_PORTS_DEF,
	parameter int COL       = 1,
	parameter int IDX_W     = $clog2(MAX_PORTS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcas_pkg::cell_cmd_t               cmd,
	input  logic [IDX_W-1:0]                  n,
	input  logic [IDX_W-1:0]                  cur,
	input  logic [IDX_W-1:0]                  set_val,
	input  logic [mcas_pkg::COST_W-1:0]       cost_in,
	output logic [mcas_pkg::COST_W-1:0]       cost_out,
	input  logic                              tok_vld_in,
	input  logic signed [mcas_pkg::VAL_W-1:0] tok_best_in,
	input  logic [IDX_W-1:0]                  tok_idx_in,
	input  logic [IDX_W-1:0]                  tok_match_in,
	output logic                              tok_vld_out,
	output logic signed [mcas_pkg::VAL_W-1:0] tok_best_out,
	output logic [IDX_W-1:0]                  tok_idx_out,
	output logic [IDX_W-1:0]                  tok_match_out,
	output logic [IDX_W-1:0]                  match_o,
	output logic [IDX_W-1:0]                  way_o
);
	import mcas_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(COL);

	logic [COST_W-1:0]       cost_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] minv_q;
	logic signed [VAL_W-1:0] t_q;
	logic signed [VAL_W-1:0] slack;
	logic                    used_q;
	logic [IDX_W-1:0]        match_q;
	logic [IDX_W-1:0]        way_q;
	logic                    tok_vld_q;
	logic signed [VAL_W-1:0] tok_best_q;
	logic [IDX_W-1:0]        tok_idx_q;
	logic [IDX_W-1:0]        tok_match_q;
	logic                    active;
	logic                    take;

	assign active = (MY_IDX <= n);
	assign slack  = t_q - cmd.arg;
	// strict less keeps the lower column on ties
	assign take   = active && !used_q && (minv_q < tok_best_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_in;
			case (cmd.op)
				CMD_ROW_INIT: begin
					used_q <= 1'b0;
				end
				CMD_MARK: begin
					if (cur == MY_IDX) begin
						used_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tok_best_q  <= take ? minv_q : tok_best_in;
		tok_idx_q   <= take ? MY_IDX : tok_idx_in;
		tok_match_q <= take ? match_q : tok_match_in;
		case (cmd.op)
			CMD_SOLVE_INIT: begin
				v_q     <= '0;
				match_q <= '0;
				way_q   <= '0;
			end
			CMD_ROW_INIT: begin
				minv_q <= SLACK_INF;
			end
			CMD_SHIFT: begin
				cost_q <= cost_in;
			end
			CMD_SUB_V: begin
				t_q <= $signed({{(VAL_W - COST_W){1'b0}}, cost_q}) - v_q;
			end
			CMD_SLACK: begin
				if (active && !used_q && (slack < minv_q)) begin
					minv_q <= slack;
					way_q  <= cur;
				end
			end
			CMD_APPLY: begin
				if (used_q) begin
					v_q <= v_q - cmd.arg;
				end else if (active) begin
					minv_q <= minv_q - cmd.arg;
				end
			end
			CMD_SET_MATCH: begin
				if (cur == MY_IDX) begin
					match_q <= set_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign cost_out      = cost_q;
	assign tok_vld_out   = tok_vld_q;
	assign tok_best_out  = tok_best_q;
	assign tok_idx_out   = tok_idx_q;
	assign tok_match_out = tok_match_q;
	assign match_o       = match_q;
	assign way_o         = way_q;
endmodule

FILE: design/min_cost_assignment_solver.sv
// Min-cost square assignment solver (Hungarian method, shortest augmenting paths).
// Depends on mcas_pkg, mcas_ifs, mcas_ram and mcas_cell.
//
// A write item (action 0) stores one 40-bit cost at (row, col); costs never written read
// as 1e12. A solve item (action 1) runs the method over the top-left n by n costs,
// n = min(ports_in_use, MAX_PORTS, 16), then returns n result items, one per row in row
// order, the final one marked with last. n = 0 returns nothing. The columns live in a
// chain of MAX_PORTS cells; each augmenting step shifts the current row's costs into the
// chain through the cost RAM read port, forms the slacks (S_SUBV, then S_SLACK), walks a
// minimum token down the chain, then applies the delta. A row takes one to n steps plus
// path reversal; a solve ends with result gathering and n result items. Input items
// are taken only while the solver is idle; the config register may be written then.
module min_cost_assignment_solver #(
	parameter int MAX_PORTS = mcas_pkg::MAX_PORTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mcas_in_if.sink    items,
	mcas_out_if.source results,
	mcas_cfg_if.sink   cfg
);
	import mcas_pkg::*;

	localparam int IDX_W = $clog2(MAX_PORTS + 1);
	localparam int RW    = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
	localparam int DEPTH = 2 ** (2 * RW);
	localparam int NCAP  = (MAX_PORTS < RESULT_CAP) ? MAX_PORTS : RESULT_CAP;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SOLVE_INIT,
		S_ROW_INIT,
		S_LOAD,
		S_SUBV,
		S_SLACK,
		S_INJ,
		S_MIN,
		S_APPLY,
		S_ENDSTEP,
		S_AUG,
		S_ASSIGN,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic [CFG_W-1:0]        ports_q;
	logic [IDX_W-1:0]        n_q;
	logic [IDX_W-1:0]        n_eff;
	logic [IDX_W-1:0]        i_q;        // row being added
	logic [IDX_W-1:0]        cur_q;      // current column of the path
	logic [IDX_W-1:0]        cmatch_q;   // row matched to cur_q
	logic [IDX_W:0]          guard_q;
	logic [IDX_W:0]          k_q;        // cost load counter
	logic [IDX_W-1:0]        j_q;
	logic [RC_W-1:0]         r_q;
	logic signed [VAL_W-1:0] delta_q;
	logic [IDX_W-1:0]        next_q;
	logic [IDX_W-1:0]        nmatch_q;
	logic signed [VAL_W-1:0] u_q [MAX_PORTS + 1];
	logic [MAX_PORTS:0]      row_vis_q;
	logic [RC_W-1:0]         assign_q [RESULT_CAP];
	logic                    ovld_q;
	logic [RC_W-1:0]         src_q;
	logic [RC_W-1:0]         tgt_q;
	logic                    last_q;
	logic                    vld_s1;
	logic [DEPTH-1:0]        vbits_q;

	// cost store
	logic                    we;
	logic                    wr_ok;
	logic                    in_acc;
	logic [2*RW-1:0]         waddr;
	logic [2*RW-1:0]         raddr;
	logic [COST_W-1:0]       rdata;
	logic [IDX_W-1:0]        rd_col;
	logic [IDX_W-1:0]        rd_row;

	// chain wiring, index 0 is the feed from this level
	cell_cmd_t               cmd;
	logic [COST_W-1:0]       cchain [MAX_PORTS + 1];
	logic                    tvld   [MAX_PORTS + 1];
	logic signed [VAL_W-1:0] tbest  [MAX_PORTS + 1];
	logic [IDX_W-1:0]        tidx   [MAX_PORTS + 1];
	logic [IDX_W-1:0]        tmatch [MAX_PORTS + 1];
	logic [IDX_W-1:0]        mt     [MAX_PORTS + 1];
	logic [IDX_W-1:0]        wy     [MAX_PORTS + 1];
	logic [IDX_W-1:0]        set_val;
	logic [IDX_W-1:0]        prev;
	logic [IDX_W-1:0]        m_sel;
	logic [IDX_W-1:0]        m_dec;
	logic [IDX_W:0]          n_p1;
	logic [IDX_W:0]          guard_p1;

	assign cfg.ready   = 1'b1;
	assign items.ready = (state_q == S_IDLE);
	assign in_acc      = items.valid && items.ready;

	assign n_eff = (int'(ports_q) > NCAP) ? IDX_W'(NCAP) : IDX_W'(ports_q);
	assign wr_ok = (int'(items.row) < MAX_PORTS) && (int'(items.col) < MAX_PORTS);
	assign we    = in_acc && (items.action == ACT_WRITE) && wr_ok;
	assign waddr = {RW'(items.row), RW'(items.col)};

	// costs go in from the last column down, so column n lands in cell n
	assign rd_col = n_q - IDX_W'(1) - k_q[IDX_W-1:0];
	assign rd_row = cmatch_q - IDX_W'(1);
	assign raddr  = {RW'(rd_row), RW'(rd_col)};

	assign n_p1     = {1'b0, n_q} + (IDX_W + 1)'(1);
	assign guard_p1 = guard_q + (IDX_W + 1)'(1);
	assign prev     = wy[cur_q];
	assign set_val  = mt[prev];
	assign m_sel    = mt[j_q];
	assign m_dec    = m_sel - IDX_W'(1);

	mcas_ram #(
		.WIDTH (COST_W),
		.DEPTH (DEPTH)
	) u_cost_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (items.cost),
		.raddr (raddr),
		.rdata (rdata)
	);

	// entries never written read as the reset cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q <= '0;
			ports_q <= CFG_RESET;
		end else begin
			if (we) begin
				vbits_q[waddr] <= 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				ports_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= vbits_q[raddr];
	end

	assign cchain[0] = vld_s1 ? rdata : COST_RESET;
	assign tvld[0]   = (state_q == S_INJ);
	assign tbest[0]  = SLACK_INF;
	assign tidx[0]   = '0;
	assign tmatch[0] = '0;
	assign mt[0]     = i_q;
	assign wy[0]     = '0;

	always_comb begin
		cmd.arg = (state_q == S_SLACK) ? u_q[cmatch_q] : delta_q;
		case (state_q)
			S_SOLVE_INIT: cmd.op = CMD_SOLVE_INIT;
			S_ROW_INIT:   cmd.op = CMD_ROW_INIT;
			S_LOAD:       cmd.op = (k_q == '0) ? CMD_MARK : CMD_SHIFT;
			S_SUBV:       cmd.op = CMD_SUB_V;
			S_SLACK:      cmd.op = CMD_SLACK;
			S_APPLY:      cmd.op = CMD_APPLY;
			S_AUG:        cmd.op = ((cur_q != '0) && (guard_q <= n_p1)) ? CMD_SET_MATCH
			                                                            : CMD_NOP;
			default:      cmd.op = CMD_NOP;
		endcase
	end

	for (genvar c = 1; c <= MAX_PORTS; c++) begin : g_cell
		mcas_cell #(
			.MAX_PORTS (MAX_PORTS),
			.COL       (c),
			.IDX_W     (IDX_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.n             (n_q),
			.cur           (cur_q),
			.set_val       (set_val),
			.cost_in       (cchain[c-1]),
			.cost_out      (cchain[c]),
			.tok_vld_in    (tvld[c-1]),
			.tok_best_in   (tbest[c-1]),
			.tok_idx_in    (tidx[c-1]),
			.tok_match_in  (tmatch[c-1]),
			.tok_vld_out   (tvld[c]),
			.tok_best_out  (tbest[c]),
			.tok_idx_out   (tidx[c]),
			.tok_match_out (tmatch[c]),
			.match_o       (mt[c]),
			.way_o         (wy[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			// while emitting, the emit arm owns the output register
			if (ovld_q && results.ready && (state_q != S_EMIT)) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (items.action == ACT_SOLVE) && (n_eff != '0)) begin
						n_q     <= n_eff;
						state_q <= S_SOLVE_INIT;
					end
				end
				S_SOLVE_INIT: begin
					for (int r = 0; r <= MAX_PORTS; r++) begin
						u_q[r] <= '0;
					end
					for (int r = 0; r < RESULT_CAP; r++) begin
						assign_q[r] <= RC_W'(r);
					end
					i_q     <= IDX_W'(1);
					state_q <= S_ROW_INIT;
				end
				S_ROW_INIT: begin
					cur_q     <= '0;
					cmatch_q  <= i_q;
					guard_q   <= '0;
					k_q       <= '0;
					row_vis_q <= '0;
					state_q   <= S_LOAD;
				end
				S_LOAD: begin
					if (k_q == '0) begin
						row_vis_q[cmatch_q] <= 1'b1;
					end
					if (k_q == {1'b0, n_q}) begin
						state_q <= S_SUBV;
					end else begin
						k_q <= k_q + (IDX_W + 1)'(1);
					end
				end
				S_SUBV: begin
					state_q <= S_SLACK;
				end
				S_SLACK: begin
					state_q <= S_INJ;
				end
				S_INJ: begin
					state_q <= S_MIN;
				end
				S_MIN: begin
					if (tvld[MAX_PORTS]) begin
						delta_q  <= tbest[MAX_PORTS];
						next_q   <= tidx[MAX_PORTS];
						nmatch_q <= tmatch[MAX_PORTS];
						state_q  <= (tidx[MAX_PORTS] == '0) ? S_ENDSTEP : S_APPLY;
					end
				end
				S_APPLY: begin
					for (int r = 0; r <= MAX_PORTS; r++) begin
						if (row_vis_q[r]) begin
							u_q[r] <= u_q[r] + delta_q;
						end
					end
					cur_q    <= next_q;
					cmatch_q <= nmatch_q;
					guard_q  <= guard_p1;
					k_q      <= '0;
					state_q  <= ((nmatch_q == '0) || (guard_p1 > n_p1)) ? S_ENDSTEP : S_LOAD;
				end
				S_ENDSTEP: begin
					guard_q <= '0;
					if (cmatch_q == '0) begin
						state_q <= S_AUG;
					end else if (i_q == n_q) begin
						j_q     <= IDX_W'(1);
						state_q <= S_ASSIGN;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_ROW_INIT;
					end
				end
				S_AUG: begin
					// walk the back links to column 0, shifting matches along the path
					if ((cur_q != '0) && (guard_q <= n_p1)) begin
						cur_q   <= prev;
						guard_q <= guard_p1;
					end else if (i_q == n_q) begin
						j_q     <= IDX_W'(1);
						state_q <= S_ASSIGN;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_ROW_INIT;
					end
				end
				S_ASSIGN: begin
					if ((m_sel != '0) && (m_sel <= n_q)) begin
						assign_q[RC_W'(m_dec)] <= RC_W'(j_q - IDX_W'(1));
					end
					if (j_q == n_q) begin
						r_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (!ovld_q || results.ready) begin
						ovld_q <= 1'b1;
						src_q  <= r_q;
						tgt_q  <= assign_q[r_q];
						last_q <= (r_q == RC_W'(n_q - IDX_W'(1)));
						if (r_q == RC_W'(n_q - IDX_W'(1))) begin
							state_q <= S_IDLE;
						end else begin
							r_q <= r_q + RC_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid           = ovld_q;
	assign results.source_row      = src_q;
	assign results.assigned_target = tgt_q;
	assign results.last            = last_q;

	// the minimum token only comes out of the chain during a search
	a_tok_in_min: assert property (@(posedge clk) disable iff (!arst_n)
		tvld[MAX_PORTS] |-> (state_q == S_MIN))
		else $error("minimum token left the chain outside a search");

	// reduced costs stay non-negative, so every applied delta does too
	a_delta_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> !delta_q[VAL_W-1])
		else $error("negative delta applied");

	// nothing follows the marked final item until a new solve has run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last) |=> !results.valid)
		else $error("result item after the final one of a solve");

	// an output item is only produced while emitting
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> ($past(state_q) == S_EMIT))
		else $error("result item produced outside the emit phase");
endmodule
